### rtl/core/stl_pkg.sv
`default_nettype none

package stl_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // Byte codes the scanner looks for.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef enum logic [4:0] {
      TOK_EXIT     = 5'd0,
      TOK_INTLIT   = 5'd1,
      TOK_SEMI     = 5'd2,
      TOK_LPAREN   = 5'd3,
      TOK_RPAREN   = 5'd4,
      TOK_FILEEND  = 5'd5,
      TOK_INT      = 5'd6,
      TOK_IDENT    = 5'd7,
      TOK_EQ       = 5'd8,
      TOK_PLUS     = 5'd9,
      TOK_MINUS    = 5'd10,
      TOK_STAR     = 5'd11,
      TOK_SLASH    = 5'd12,
      TOK_LCURL    = 5'd13,
      TOK_RCURL    = 5'd14,
      TOK_COMMA    = 5'd15,
      TOK_RETURN   = 5'd16,
      TOK_UNCLOSED = 5'd17
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [15:0]  start;
      logic [15:0]  length;
      logic         last;
   } result_type;

   // Up to two results leave the scanner for one byte.
   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } scan_out_type;

   localparam logic [15:0] KW_LEN [3] = '{16'd4, 16'd3, 16'd6};
   localparam tok_kind_type KW_KIND [3] = '{TOK_EXIT, TOK_INT, TOK_RETURN};

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Character idx of keyword k (0 exit, 1 int, 2 return).
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] c;
      c = CH_NUL;
      unique case (k)
         2'd0: begin
            unique case (idx)
               3'd0: c = "e";
               3'd1: c = "x";
               3'd2: c = "i";
               3'd3: c = "t";
               default: c = CH_NUL;
            endcase
         end
         2'd1: begin
            unique case (idx)
               3'd0: c = "i";
               3'd1: c = "n";
               3'd2: c = "t";
               default: c = CH_NUL;
            endcase
         end
         2'd2: begin
            unique case (idx)
               3'd0: c = "r";
               3'd1: c = "e";
               3'd2: c = "t";
               3'd3: c = "u";
               3'd4: c = "r";
               3'd5: c = "n";
               default: c = CH_NUL;
            endcase
         end
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // Drops every keyword that the byte at offset len of the word rules out.
   function automatic logic [2:0] kw_keep(input logic [2:0] kw, input logic [15:0] len,
                                          input logic [7:0] c);
      logic [2:0] keep;
      for (int k = 0; k < 3; k++) begin
         keep[k] = kw[k] && (len < KW_LEN[k]) && (kw_char(2'(k), len[2:0]) == c);
      end
      return keep;
   endfunction

   function automatic tok_kind_type word_kind(input logic [2:0] kw, input logic [15:0] len);
      tok_kind_type kind;
      kind = TOK_IDENT;
      for (int k = 0; k < 3; k++) begin
         if (kw[k] && len == KW_LEN[k]) begin
            kind = KW_KIND[k];
         end
      end
      return kind;
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return c == ";" || c == "(" || c == ")" || c == "=" || c == "+" || c == "-" ||
             c == CH_STAR || c == "{" || c == "}" || c == ",";
   endfunction

   function automatic tok_kind_type single_kind(input logic [7:0] c);
      tok_kind_type kind;
      kind = TOK_SEMI;
      unique case (c)
         "(":     kind = TOK_LPAREN;
         ")":     kind = TOK_RPAREN;
         "=":     kind = TOK_EQ;
         "+":     kind = TOK_PLUS;
         "-":     kind = TOK_MINUS;
         CH_STAR: kind = TOK_STAR;
         "{":     kind = TOK_LCURL;
         "}":     kind = TOK_RCURL;
         ",":     kind = TOK_COMMA;
         default: kind = TOK_SEMI;
      endcase
      return kind;
   endfunction

   function automatic result_type make_res(input tok_kind_type kind, input logic [15:0] start,
                                           input logic [15:0] length);
      result_type r;
      r.kind   = kind;
      r.start  = start;
      r.length = length;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/source_text_lexer.sv
// Channel  | Direction | Handshake                | Beat contents
// req      | in        | req_valid / req_stall    | req_ch: one source byte, 0 ends the text
// rsp      | out       | rsp_valid / rsp_stall    | token type, start, length, last_of_run
//
// A byte is taken into an input register; from there the scanner processes it and
// writes zero, one or two token beats into a four-entry queue, whose head drives rsp.
// With rsp never stalled a byte is taken every cycle while the queue keeps room for two;
// a long run of two-token bytes settles at the drain rate, one token beat per cycle.
// Reset is synchronous and puts the scanner at offset 0, idle between tokens.
// req_stall rises while a byte waits and the queue has fewer than two free slots.
`default_nettype none

module source_text_lexer #(
   parameter int POS_BITS = stl_pkg::POS_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_ch,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output stl_pkg::tok_kind_type       rsp_token_type,
   output logic [15:0]                 rsp_tok_start,
   output logic [15:0]                 rsp_tok_length,
   output logic                        rsp_last_of_run
);

   // Input register: holds one byte until the scanner can take it.
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_ch_ff;
   logic                  accept;
   logic                  take;
   logic                  room2;
   stl_pkg::scan_out_type scan_out;
   stl_pkg::result_type   out_res;

   // The scanner consumes the held byte whenever the queue can absorb the
   // worst case of two tokens, so the input register frees up in the same cycle.
   assign take      = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff <= req_ch;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   stl_scan #(
      .POS_BITS (POS_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .ch       (in_ch_ff),
      .scan_out (scan_out)
   );

   stl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .scan_out  (scan_out),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   // Result beat fields come straight from the queue head.
   assign rsp_token_type  = out_res.kind;
   assign rsp_tok_start   = out_res.start;
   assign rsp_tok_length  = out_res.length;
   assign rsp_last_of_run = out_res.last;

endmodule

`default_nettype wire

### rtl/core/stl_scan.sv
`default_nettype none

// Scan state and the per-byte next-state logic.
module stl_scan #(
   parameter int POS_BITS = stl_pkg::POS_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [7:0]           ch,
   output stl_pkg::scan_out_type     scan_out
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_WORD  = 3'd1,
      MODE_NUM   = 3'd2,
      MODE_SLASH = 3'd3,
      MODE_LINE  = 3'd4,
      MODE_BLOCK = 3'd5,
      MODE_BSTAR = 3'd6
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   start_ff, start_in;
   logic [15:0]           len_ff, len_in;
   logic [2:0]            kw_ff, kw_in;
   logic [15:0]           len_grow;
   logic                  as_idle;
   logic                  clear;
   stl_pkg::result_type   idle_res;
   logic                  idle_emit;

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff + POS_BITS'(1);
      start_in  = start_ff;
      len_in    = len_ff;
      kw_in     = kw_ff;
      as_idle   = 1'b0;
      clear     = 1'b0;
      idle_emit = 1'b0;
      idle_res  = stl_pkg::make_res(stl_pkg::TOK_FILEEND, 16'(pos_ff), 16'd0);
      scan_out  = '0;
      len_grow  = (len_ff == stl_pkg::LEN_MAX) ? len_ff : len_ff + 16'd1;

      unique case (mode_ff)
         MODE_WORD: begin
            if (ch != stl_pkg::CH_NUL && (stl_pkg::is_letter(ch) || stl_pkg::is_digit(ch))) begin
               kw_in  = stl_pkg::kw_keep(kw_ff, len_ff, ch);
               len_in = len_grow;
            end else begin
               scan_out.v0 = 1'b1;
               scan_out.r0 = stl_pkg::make_res(stl_pkg::word_kind(kw_ff, len_ff),
                                               16'(start_ff), len_ff);
               as_idle     = 1'b1;
            end
         end
         MODE_NUM: begin
            if (stl_pkg::is_digit(ch)) begin
               len_in = len_grow;
            end else begin
               scan_out.v0 = 1'b1;
               scan_out.r0 = stl_pkg::make_res(stl_pkg::TOK_INTLIT, 16'(start_ff), len_ff);
               as_idle     = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (ch == stl_pkg::CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (ch == stl_pkg::CH_STAR) begin
               mode_in = MODE_BLOCK;
               len_in  = len_grow;
            end else begin
               scan_out.v0 = 1'b1;
               scan_out.r0 = stl_pkg::make_res(stl_pkg::TOK_SLASH, 16'(start_ff), 16'd1);
               as_idle     = 1'b1;
            end
         end
         MODE_LINE: begin
            if (ch == stl_pkg::CH_NUL) begin
               as_idle = 1'b1;
            end else if (ch == stl_pkg::CH_NL) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_BLOCK, MODE_BSTAR: begin
            if (ch == stl_pkg::CH_NUL) begin
               scan_out.v0 = 1'b1;
               scan_out.r0 = stl_pkg::make_res(stl_pkg::TOK_UNCLOSED, 16'(start_ff), len_ff);
               clear       = 1'b1;
            end else begin
               len_in = len_grow;
               if (ch == stl_pkg::CH_STAR) begin
                  mode_in = MODE_BSTAR;
               end else if (ch == stl_pkg::CH_SLASH && mode_ff == MODE_BSTAR) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = MODE_BLOCK;
               end
            end
         end
         default: begin
            as_idle = 1'b1;
         end
      endcase

      if (as_idle) begin
         mode_in = MODE_IDLE;
         if (ch == stl_pkg::CH_NUL) begin
            idle_emit = 1'b1;
            clear     = 1'b1;
         end else if (stl_pkg::is_letter(ch)) begin
            mode_in  = MODE_WORD;
            start_in = pos_ff;
            kw_in    = stl_pkg::kw_keep(3'b111, 16'd0, ch);
            len_in   = 16'd1;
         end else if (stl_pkg::is_digit(ch)) begin
            mode_in  = MODE_NUM;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (ch == stl_pkg::CH_SLASH) begin
            mode_in  = MODE_SLASH;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (stl_pkg::is_single(ch)) begin
            idle_emit = 1'b1;
            idle_res  = stl_pkg::make_res(stl_pkg::single_kind(ch), 16'(pos_ff), 16'd1);
         end
      end

      if (idle_emit) begin
         if (scan_out.v0) begin
            scan_out.v1 = 1'b1;
            scan_out.r1 = idle_res;
         end else begin
            scan_out.v0 = 1'b1;
            scan_out.r0 = idle_res;
         end
      end
      scan_out.r0.last = !scan_out.v1;
      scan_out.r1.last = 1'b1;

      if (clear) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = 16'd0;
         kw_in    = 3'b111;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= 16'd0;
         kw_ff    <= 3'b111;
      end else if (take) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/stl_outq.sv
`default_nettype none

// Four-entry result queue: up to two writes per cycle, one read.
module stl_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire stl_pkg::scan_out_type scan_out,
   output logic                       room2,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output stl_pkg::result_type        out_res
);

   stl_pkg::result_type entries_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [2:0] n_push;

   assign room2     = count_ff <= 3'd2;
   assign out_valid = count_ff != 3'd0;
   assign out_res   = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      n_push = 3'd0;
      if (push) begin
         n_push = {2'b00, scan_out.v0} + {2'b00, scan_out.v1};
      end
      wr_ptr_in = wr_ptr_ff + n_push[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + n_push - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push && scan_out.v0) begin
         entries_ff[wr_ptr_ff] <= scan_out.r0;
      end
      if (push && scan_out.v1) begin
         entries_ff[wr_ptr_ff + 2'd1] <= scan_out.r1;
      end
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/stl_checker.sv
`default_nettype none

module stl_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire stl_pkg::tok_kind_type rsp_token_type,
   input wire logic [15:0]           rsp_tok_start,
   input wire logic [15:0]           rsp_tok_length,
   input wire logic                  rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_type) &&
      $stable(rsp_tok_start) && $stable(rsp_tok_length) && $stable(rsp_last_of_run))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_fileend_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == stl_pkg::TOK_FILEEND |->
      rsp_last_of_run && rsp_tok_length == 16'd0)
      else $error("file end beat not last or not empty");

   a_unclosed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == stl_pkg::TOK_UNCLOSED |-> rsp_last_of_run)
      else $error("unclosed comment beat not last of its byte");

   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_type == stl_pkg::TOK_SEMI ||
                    rsp_token_type == stl_pkg::TOK_SLASH ||
                    rsp_token_type == stl_pkg::TOK_COMMA) |-> rsp_tok_length == 16'd1)
      else $error("punctuation beat with length other than one");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_token_type  (rsp_token_type),
   .rsp_tok_start   (rsp_tok_start),
   .rsp_tok_length  (rsp_tok_length),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire

### verif/token_checker.sv
`timescale 1ns / 100ps

module token_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_ch,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire stl_pkg::tok_kind_type rsp_token_type,
   input  wire logic [15:0]           rsp_tok_start,
   input  wire logic [15:0]           rsp_tok_length,
   input  wire logic                  rsp_last_of_run,
   output int                         fail_count,
   output int                         pending,
   output int                         tokens_checked,
   output int                         texts_closed
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_NUMBER,
      SCAN_SLASH,
      SCAN_LINE_CMT,
      SCAN_BLOCK_CMT,
      SCAN_BLOCK_STAR
   } scan_state_type;

   string kw_words [3] = '{"exit", "int", "return"};

   scan_state_type       mode;
   logic [15:0]          offset;
   logic [15:0]          item_start;
   logic [15:0]          item_len;
   logic [2:0]           kw_live;
   stl_pkg::result_type  token_q [$];
   stl_pkg::result_type  byte_tokens [$];

   function automatic logic word_lead(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == stl_pkg::CH_UNDER;
   endfunction

   function automatic logic decimal(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void lengthen();
      if (item_len != stl_pkg::LEN_MAX) begin
         item_len = item_len + 16'd1;
      end
   endfunction

   // A keyword stays possible only while each byte matches it at its offset.
   function automatic void narrow_keywords(input logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
         if (!(item_len < kw_words[k].len() && kw_words[k][item_len] == c)) begin
            kw_live[k] = 1'b0;
         end
      end
   endfunction

   function automatic stl_pkg::tok_kind_type finished_word();
      stl_pkg::tok_kind_type kind;
      kind = stl_pkg::TOK_IDENT;
      if (kw_live[0] && item_len == 16'd4) kind = stl_pkg::TOK_EXIT;
      if (kw_live[1] && item_len == 16'd3) kind = stl_pkg::TOK_INT;
      if (kw_live[2] && item_len == 16'd6) kind = stl_pkg::TOK_RETURN;
      return kind;
   endfunction

   function automatic void add_token(input stl_pkg::tok_kind_type kind, input logic [15:0] start,
                                     input logic [15:0] length);
      stl_pkg::result_type r;
      r.kind   = kind;
      r.start  = start;
      r.length = length;
      r.last   = 1'b0;
      if (byte_tokens.size() < 2) begin
         byte_tokens.push_back(r);
      end
   endfunction

   function automatic void restart_text();
      mode       = SCAN_IDLE;
      offset     = '0;
      item_start = '0;
      item_len   = '0;
      kw_live    = 3'b111;
   endfunction

   function automatic void from_idle(input logic [7:0] c);
      if (word_lead(c)) begin
         mode       = SCAN_WORD;
         item_start = offset;
         item_len   = '0;
         kw_live    = 3'b111;
         narrow_keywords(c);
         item_len   = 16'd1;
      end else if (decimal(c)) begin
         mode       = SCAN_NUMBER;
         item_start = offset;
         item_len   = 16'd1;
      end else if (c == stl_pkg::CH_SLASH) begin
         mode       = SCAN_SLASH;
         item_start = offset;
         item_len   = 16'd1;
      end else begin
         case (c)
            ";":              add_token(stl_pkg::TOK_SEMI,   offset, 16'd1);
            "(":              add_token(stl_pkg::TOK_LPAREN, offset, 16'd1);
            ")":              add_token(stl_pkg::TOK_RPAREN, offset, 16'd1);
            "=":              add_token(stl_pkg::TOK_EQ,     offset, 16'd1);
            "+":              add_token(stl_pkg::TOK_PLUS,   offset, 16'd1);
            "-":              add_token(stl_pkg::TOK_MINUS,  offset, 16'd1);
            stl_pkg::CH_STAR: add_token(stl_pkg::TOK_STAR,   offset, 16'd1);
            "{":              add_token(stl_pkg::TOK_LCURL,  offset, 16'd1);
            "}":              add_token(stl_pkg::TOK_RCURL,  offset, 16'd1);
            ",":              add_token(stl_pkg::TOK_COMMA,  offset, 16'd1);
            default: ;
         endcase
      end
   endfunction

   // Works out the token beats that one accepted source byte produces.
   function automatic void scan_byte(input logic [7:0] c);
      logic                rescan;
      logic                text_done;
      stl_pkg::result_type r;
      byte_tokens.delete();
      rescan    = 1'b0;
      text_done = 1'b0;
      case (mode)
         SCAN_WORD: begin
            if (c != stl_pkg::CH_NUL && (word_lead(c) || decimal(c))) begin
               narrow_keywords(c);
               lengthen();
            end else begin
               add_token(finished_word(), item_start, item_len);
               rescan = 1'b1;
            end
         end
         SCAN_NUMBER: begin
            if (decimal(c)) begin
               lengthen();
            end else begin
               add_token(stl_pkg::TOK_INTLIT, item_start, item_len);
               rescan = 1'b1;
            end
         end
         SCAN_SLASH: begin
            if (c == stl_pkg::CH_SLASH) begin
               mode = SCAN_LINE_CMT;
            end else if (c == stl_pkg::CH_STAR) begin
               mode = SCAN_BLOCK_CMT;
               lengthen();
            end else begin
               add_token(stl_pkg::TOK_SLASH, item_start, 16'd1);
               rescan = 1'b1;
            end
         end
         SCAN_LINE_CMT: begin
            if (c == stl_pkg::CH_NUL) begin
               rescan = 1'b1;
            end else if (c == stl_pkg::CH_NL) begin
               mode = SCAN_IDLE;
            end
         end
         SCAN_BLOCK_CMT, SCAN_BLOCK_STAR: begin
            if (c == stl_pkg::CH_NUL) begin
               add_token(stl_pkg::TOK_UNCLOSED, item_start, item_len);
               restart_text();
               text_done = 1'b1;
            end else begin
               lengthen();
               if (c == stl_pkg::CH_STAR) begin
                  mode = SCAN_BLOCK_STAR;
               end else if (c == stl_pkg::CH_SLASH && mode == SCAN_BLOCK_STAR) begin
                  mode = SCAN_IDLE;
               end else begin
                  mode = SCAN_BLOCK_CMT;
               end
            end
         end
         default: rescan = 1'b1;
      endcase

      if (rescan) begin
         mode = SCAN_IDLE;
         if (c == stl_pkg::CH_NUL) begin
            add_token(stl_pkg::TOK_FILEEND, offset, 16'd0);
            restart_text();
            text_done = 1'b1;
         end else begin
            from_idle(c);
         end
      end
      if (!text_done) begin
         offset = offset + 16'd1;
      end
      if (byte_tokens.size() > 0) begin
         r = byte_tokens.pop_back();
         r.last = 1'b1;
         byte_tokens.push_back(r);
      end
      foreach (byte_tokens[i]) begin
         token_q.push_back(byte_tokens[i]);
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      stl_pkg::result_type want;
      if (reset) begin
         restart_text();
         token_q.delete();
         fail_count     = 0;
         tokens_checked = 0;
         texts_closed   = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (token_q.size() == 0) begin
               fail_count++;
               $display("%0t: expected no token beat, got type %0d start %0d length %0d",
                        $time, rsp_token_type, rsp_tok_start, rsp_tok_length);
            end else begin
               want = token_q.pop_front();
               if (rsp_token_type !== want.kind) begin
                  report_mismatch("token_type", 16'(want.kind), 16'(rsp_token_type));
               end
               if (rsp_tok_start !== want.start) begin
                  report_mismatch("tok_start", want.start, rsp_tok_start);
               end
               if (rsp_tok_length !== want.length) begin
                  report_mismatch("tok_length", want.length, rsp_tok_length);
               end
               if (rsp_last_of_run !== want.last) begin
                  report_mismatch("last_of_run", 16'(want.last), 16'(rsp_last_of_run));
               end
               tokens_checked++;
               if (want.kind == stl_pkg::TOK_FILEEND || want.kind == stl_pkg::TOK_UNCLOSED) begin
                  texts_closed++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            scan_byte(req_ch);
         end
      end
      pending = token_q.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_ch;
   logic                  rsp_valid;
   logic                  rsp_stall;
   stl_pkg::tok_kind_type rsp_token_type;
   logic [15:0]           rsp_tok_start;
   logic [15:0]           rsp_tok_length;
   logic                  rsp_last_of_run;

   int fail_count;
   int pending;
   int tokens_checked;
   int texts_closed;

   // Source bytes waiting to be offered to the scanner, in text order.
   logic [7:0] source_q [$];
   int         bytes_sent;

   // While steady is set neither side idles. Each increment of long_holds asks
   // the token side for one long stall while bytes keep coming.
   bit         steady;
   int         long_holds;

   string      kw_words [3] = '{"exit", "int", "return"};

   source_text_lexer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_type  (rsp_token_type),
      .rsp_tok_start   (rsp_tok_start),
      .rsp_tok_length  (rsp_tok_length),
      .rsp_last_of_run (rsp_last_of_run)
   );

   token_checker u_token_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_type  (rsp_token_type),
      .rsp_tok_start   (rsp_tok_start),
      .rsp_tok_length  (rsp_tok_length),
      .rsp_last_of_run (rsp_last_of_run),
      .fail_count      (fail_count),
      .pending         (pending),
      .tokens_checked  (tokens_checked),
      .texts_closed    (texts_closed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Even with the longest idles on both sides the run should end well before this
   // point, which leaves a wide margin before the run is declared hung.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // Idle stretches are mostly absent or short, now and then long.
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      else if (pick < 90) return $urandom_range(1, 3);
      else if (pick < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // The token side stalls on its own schedule. A long hold request makes it
   // stall without a break, long enough for the scanner's queue to fill and
   // for req_stall to push back on the byte side.
   initial begin : token_side
      int hold;
      int seen_holds;
      hold       = 0;
      seen_holds = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (long_holds != seen_holds) begin
            seen_holds = long_holds;
            hold = 80;
         end else if (hold == 0 && !steady) begin
            hold = idle_len();
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one byte and returns once the scanner has taken it. Valid only
   // drops when a gap is inserted, so back-to-back beats keep it high.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_queued();
      while (source_q.size() > 0) begin
         send_byte(source_q.pop_front());
      end
   endtask

   // Stops offering bytes until every predicted token beat has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         source_q.push_back(s[i]);
      end
   endtask

   // A byte that may appear inside a word; digits are left out for a lead.
   function automatic logic [7:0] word_byte(input bit lead);
      int pick;
      pick = $urandom_range(0, lead ? 52 : 62);
      if (pick < 26) return 8'("a") + 8'(pick);
      else if (pick < 52) return 8'("A") + 8'(pick - 26);
      else if (pick == 52) return stl_pkg::CH_UNDER;
      else return 8'("0") + 8'(pick - 53);
   endfunction

   // Comment body bytes: anything but the zero end marker and the newline.
   function automatic logic [7:0] comment_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == stl_pkg::CH_NL) b = 8'h20;
      return b;
   endfunction

   // Appends one lexical fragment of a C-like text, occasionally garbage.
   task automatic add_fragment();
      int    pick;
      int    n;
      string kw;
      string filler;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         add_text(kw_words[$urandom_range(0, 2)]);
      end else if (pick < 22) begin
         // A keyword cut short or grown by one byte must stay an identifier.
         kw = kw_words[$urandom_range(0, 2)];
         n  = $urandom_range(1, kw.len());
         add_text(kw.substr(0, n - 1));
         if (n == kw.len()) source_q.push_back(word_byte(1'b0));
      end else if (pick < 34) begin
         source_q.push_back(word_byte(1'b1));
         n = $urandom_range(0, 7);
         repeat (n) source_q.push_back(word_byte(1'b0));
      end else if (pick < 44) begin
         n = $urandom_range(1, 6);
         repeat (n) source_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
      end else if (pick < 62) begin
         filler = ";(){}=+-*,";
         source_q.push_back(filler[$urandom_range(0, filler.len() - 1)]);
      end else if (pick < 74) begin
         case ($urandom_range(0, 3))
            0: source_q.push_back(8'h20);
            1: source_q.push_back(stl_pkg::CH_NL);
            2: source_q.push_back(8'($urandom_range(128, 255)));
            default: begin
               filler = "#@!$%.:<>?[]^|~\t";
               source_q.push_back(filler[$urandom_range(0, filler.len() - 1)]);
            end
         endcase
      end else if (pick < 80) begin
         add_text("//");
         n = $urandom_range(0, 10);
         repeat (n) source_q.push_back(comment_byte());
         source_q.push_back(stl_pkg::CH_NL);
      end else if (pick < 88) begin
         // Half of the block comments open with the slash-star-slash form,
         // whose trailing slash must not close them.
         add_text($urandom_range(0, 1) ? "/*/" : "/*");
         filler = "ab */x";
         n = $urandom_range(0, 8);
         repeat (n) source_q.push_back(filler[$urandom_range(0, filler.len() - 1)]);
         add_text("*/");
      end else if (pick < 92) begin
         source_q.push_back(stl_pkg::CH_SLASH);
      end else begin
         source_q.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 99) < 40) source_q.push_back(8'h20);
   endtask

   // Closes the current text now and then: plainly, inside a block comment
   // so that it is reported unclosed, or inside a line comment.
   task automatic maybe_end_text();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         source_q.push_back(stl_pkg::CH_NUL);
      end else if (pick < 6) begin
         add_text("/*");
         n = $urandom_range(0, 6);
         repeat (n) source_q.push_back(comment_byte());
         source_q.push_back(stl_pkg::CH_NUL);
      end else if (pick < 7) begin
         add_text("//");
         n = $urandom_range(0, 6);
         repeat (n) source_q.push_back(comment_byte());
         source_q.push_back(stl_pkg::CH_NUL);
      end
   endtask

   initial begin : byte_side
      int total;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_ch     = stl_pkg::CH_NUL;
      steady     = 1'b0;
      long_holds = 0;
      bytes_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed text. Every token kind appears, words and numbers end on the
      // byte that starts the next token, a lone slash is followed by a word,
      // the slash-star-slash opening does not close, the byte after a closing
      // star-slash is scanned, the top byte values are skipped, and a line
      // comment ends at a newline. The text ends on a word, so one byte flushes
      // it and reports the file end. Two more texts check an unclosed block
      // comment and a line comment cut off by the end of text.
      add_text("exit(int)return;7{a}=+-*,/*/*/b/x");
      source_q.push_back(8'hFF);
      add_text("//");
      source_q.push_back(8'h80);
      add_text("\nq");
      source_q.push_back(stl_pkg::CH_NUL);
      add_text("/*");
      source_q.push_back(stl_pkg::CH_NUL);
      add_text("//");
      source_q.push_back(stl_pkg::CH_NUL);
      send_queued();

      // Random texts built from well-formed fragments with some noise.
      while (source_q.size() < 600) begin
         add_fragment();
         maybe_end_text();
      end
      source_q.push_back(stl_pkg::CH_NUL);
      total = source_q.size();
      for (int i = 0; i < total; i++) begin
         if (i == 150) long_holds++;
         if (i == 400) wait_drained();
         // A stretch with no idling on either side.
         steady = (i >= 500 && i < 560);
         send_byte(source_q[i]);
      end
      source_q.delete();
      steady = 1'b0;

      // Let every predicted beat arrive, then keep watching the scanner in case
      // it emits something it should not.
      wait_drained();
      repeat (12) @(posedge clock);

      $display("Scanned %0d source bytes in %0d texts and checked %0d token beats,",
               bytes_sent, texts_closed, tokens_checked);
      $display("including keywords, comments, unclosed texts and back pressure.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
